// File: rtl/core/jsmc_pkg.sv
`default_nettype none
package jsmc_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 256;
	localparam int unsigned ID_WIDTH_DEF    = 32;

	localparam int unsigned INDEX_W    = 8;
	localparam int unsigned VALUE_W    = 32;
	localparam int unsigned POSITION_W = 8;
	localparam int unsigned MOVES_W    = 10;
	localparam int unsigned CFG_W      = 9;
	localparam int unsigned CFG_IDX_W  = 1;

	localparam logic [MOVES_W-1:0] MOVES_MAX = '1;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_JUMP_STEP   = 1'd1;

	localparam logic [CFG_W-1:0] ENTRY_COUNT_RST = 9'd0;
	localparam logic [CFG_W-1:0] JUMP_STEP_RST   = 9'd1;

	typedef struct packed {
		logic load_wr;
		logic start;
		logic rd_en;
		logic jump_adv;
		logic scan_init;
		logic scan_step;
		logic pos_inc;
		logic hit;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic pos_lt_n;
		logic pos_zero;
		logic eq;
		logic gt;
	} dp_status_t;

endpackage
`default_nettype wire

// File: rtl/core/jsmc_ram.sv
`default_nettype none
module jsmc_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/jsmc_dp.sv
`default_nettype none
module jsmc_dp #(
	parameter int unsigned TABLE_DEPTH = jsmc_pkg::TABLE_DEPTH_DEF,
	parameter int unsigned ID_WIDTH    = jsmc_pkg::ID_WIDTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire jsmc_pkg::dp_cmd_t                     ctl,
	output      jsmc_pkg::dp_status_t                  sts,
	input  wire logic [jsmc_pkg::INDEX_W-1:0]          index,
	input  wire logic signed [jsmc_pkg::VALUE_W-1:0]   value,
	input  wire logic                                  cfg_we,
	input  wire logic [jsmc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [jsmc_pkg::CFG_W-1:0]            cfg_wdata,
	output      logic                                  found,
	output      logic [jsmc_pkg::POSITION_W-1:0]       position,
	output      logic [jsmc_pkg::MOVES_W-1:0]          moves
);
	import jsmc_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned PW = $clog2(TABLE_DEPTH + 512);
	localparam logic [ID_WIDTH-1:0] SIGN_MSK = {1'b1, {(ID_WIDTH-1){1'b0}}};

	logic [CFG_W-1:0]    entry_count_q;
	logic [CFG_W-1:0]    jump_step_q;
	logic [ID_WIDTH-1:0] key_q;
	logic [PW-1:0]       pos_q;
	logic [CW-1:0]       n_q;
	logic [CFG_W-1:0]    step_q;
	logic [MOVES_W-1:0]  moves_q;
	logic                found_q;

	logic signed [ID_WIDTH-1:0] id_ext;
	logic [ID_WIDTH-1:0]        id_b;
	logic [ID_WIDTH-1:0]        rdata;
	logic                       idx_ok;
	logic [PW-1:0]              step_ext;
	logic [PW-1:0]              pos_back;
	logic [CFG_W-1:0]           add_amt;
	logic [MOVES_W:0]           moves_sum;

	// biased form: sign bit flipped so an unsigned compare gives signed order
	assign id_ext = ID_WIDTH'(value);
	assign id_b   = id_ext ^ SIGN_MSK;
	assign idx_ok = 32'(index) < 32'(TABLE_DEPTH);

	jsmc_ram #(
		.WIDTH(ID_WIDTH),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ctl.load_wr && idx_ok),
		.waddr(AW'(index)),
		.wdata(id_b),
		.re   (ctl.rd_en),
		.raddr(pos_q[AW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= ENTRY_COUNT_RST;
			jump_step_q   <= JUMP_STEP_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_ENTRY_COUNT) begin
				entry_count_q <= cfg_wdata;
			end
			if (cfg_index == REG_JUMP_STEP) begin
				jump_step_q <= cfg_wdata;
			end
		end
	end

	assign step_ext  = PW'(step_q);
	assign pos_back  = (pos_q >= step_ext) ? pos_q - step_ext : '0;
	assign add_amt   = ctl.scan_step ? CFG_W'(1) : step_q;
	assign moves_sum = {1'b0, moves_q} + (MOVES_W + 1)'(add_amt);

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			key_q   <= id_b;
			pos_q   <= '0;
			moves_q <= '0;
			found_q <= 1'b0;
			n_q     <= (32'(entry_count_q) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
			                                                  : CW'(entry_count_q);
			step_q  <= (jump_step_q == '0) ? CFG_W'(1) : jump_step_q;
		end else begin
			priority if (ctl.jump_adv) begin
				pos_q <= pos_q + step_ext;
			end else if (ctl.scan_init) begin
				pos_q <= pos_back;
			end else if (ctl.pos_inc) begin
				pos_q <= pos_q + PW'(1);
			end
			if (ctl.jump_adv || ctl.scan_init || ctl.scan_step) begin
				moves_q <= moves_sum[MOVES_W] ? MOVES_MAX : moves_sum[MOVES_W-1:0];
			end
			if (ctl.hit) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			found    <= found_q;
			position <= found_q ? pos_q[POSITION_W-1:0] : '0;
			moves    <= moves_q;
		end
	end

	assign sts.pos_lt_n = pos_q < PW'(n_q);
	assign sts.pos_zero = pos_q == '0;
	assign sts.eq       = rdata == key_q;
	assign sts.gt       = rdata > key_q;

endmodule
`default_nettype wire

// File: rtl/core/jsmc_ctrl.sv
`default_nettype none
module jsmc_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 cmd,
	output      logic                 in_stall,
	output      logic                 out_valid,
	input  wire logic                 out_stall,
	output      jsmc_pkg::dp_cmd_t    ctl,
	input  wire jsmc_pkg::dp_status_t sts
);
	import jsmc_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_JCHK = 7'b0000010,
		ST_JCMP = 7'b0000100,
		ST_SINIT = 7'b0001000,
		ST_SCHK = 7'b0010000,
		ST_SCMP = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (cmd == CMD_QUERY) begin
						ctl.start = 1'b1;
						state_d   = ST_JCHK;
					end else begin
						ctl.load_wr = 1'b1;
					end
				end
			end
			ST_JCHK: begin
				if (sts.pos_lt_n) begin
					ctl.rd_en = 1'b1;
					state_d   = ST_JCMP;
				end else if (sts.pos_zero) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_SINIT;
				end
			end
			ST_JCMP: begin
				if (sts.eq) begin
					ctl.hit = 1'b1;
					state_d = ST_FIN;
				end else if (sts.gt) begin
					state_d = ST_SINIT;
				end else begin
					ctl.jump_adv = 1'b1;
					state_d      = ST_JCHK;
				end
			end
			ST_SINIT: begin
				ctl.scan_init = 1'b1;
				state_d       = ST_SCHK;
			end
			ST_SCHK: begin
				if (sts.pos_lt_n) begin
					ctl.rd_en = 1'b1;
					state_d   = ST_SCMP;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_SCMP: begin
				ctl.scan_step = 1'b1;
				if (sts.eq) begin
					ctl.hit = 1'b1;
					state_d = ST_FIN;
				end else if (sts.gt) begin
					state_d = ST_FIN;
				end else begin
					ctl.pos_inc = 1'b1;
					state_d     = ST_SCHK;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					ctl.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// File: rtl/core/jump_search_move_counter.sv
// Jump search over a table of signed IDs, with a saturating move count.
// Input channel (in_valid/in_stall): cmd selects a load or a query. A load
// writes value into slot index and produces no result; slots at or
// beyond TABLE_DEPTH are dropped. A query searches for value among
// the first entry_count slots, which must be loaded and ascending.
// Output channel (out_valid/out_stall): one result per query with found,
// position (0 when not found) and moves (saturates at 1023).
// Config port: cfg_we writes cfg_wdata to entry_count (index 0) or
// jump_step (index 1); the user writes only while idle, the block does not enforce it.
// Flow: each table read is followed by a compare of the read word. One
// query is in flight at a time; a finished result sits in the output
// register, so the next request is taken while it waits. If the output is
// still stalled when the next query ends, that query holds and in_stall
// stays high.
// Reset clears the state machine, the output valid and the registers
// (entry_count 0, jump_step 1); table contents are undefined until loaded.
`default_nettype none
module jump_search_move_counter #(
	parameter int unsigned TABLE_DEPTH = jsmc_pkg::TABLE_DEPTH_DEF,
	parameter int unsigned ID_WIDTH    = jsmc_pkg::ID_WIDTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output      logic                                in_stall,
	input  wire logic                                cmd,
	input  wire logic [jsmc_pkg::INDEX_W-1:0]        index,
	input  wire logic signed [jsmc_pkg::VALUE_W-1:0] value,
	output      logic                                out_valid,
	input  wire logic                                out_stall,
	output      logic                                found,
	output      logic [jsmc_pkg::POSITION_W-1:0]     position,
	output      logic [jsmc_pkg::MOVES_W-1:0]        moves,
	input  wire logic                                cfg_we,
	input  wire logic [jsmc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [jsmc_pkg::CFG_W-1:0]          cfg_wdata
);
	import jsmc_pkg::*;

	dp_cmd_t    ctl;
	dp_status_t sts;

	jsmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.ctl      (ctl),
		.sts      (sts)
	);

	jsmc_dp #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.ID_WIDTH   (ID_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.sts      (sts),
		.index    (index),
		.value    (value),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.found    (found),
		.position (position),
		.moves    (moves)
	);

endmodule
`default_nettype wire

// File: rtl/core/jsmc_checker.sv
`default_nettype none
module jsmc_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            in_valid,
	input wire logic                            in_stall,
	input wire logic                            cmd,
	input wire logic                            out_valid,
	input wire logic                            out_stall,
	input wire logic                            found,
	input wire logic [jsmc_pkg::POSITION_W-1:0] position,
	input wire logic [jsmc_pkg::MOVES_W-1:0]    moves
);
	import jsmc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found) && $stable(position)
			&& $stable(moves))
		else $error("result changed while stalled");

	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> position == '0)
		else $error("miss with nonzero position");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd == CMD_QUERY |=> in_stall)
		else $error("query did not occupy the block");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd == CMD_LOAD |=> !in_stall)
		else $error("load stalled the input");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a query in progress");

endmodule

bind jump_search_move_counter jsmc_checker u_jsmc_checker (.*);
`default_nettype wire

// File: tb/jump_search_move_counter_tb.sv
`timescale 1ns / 1ps
module jump_search_move_counter_tb;
	import jsmc_pkg::*;

	localparam int unsigned SLOTS          = TABLE_DEPTH_DEF;
	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned SETTLE_CYCLES  = 10;
	localparam int unsigned DRAIN_CYCLES   = 100;
	localparam int unsigned PLANNED_TARGET = 1060;
	localparam logic signed [VALUE_W-1:0] ID_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
	localparam logic signed [VALUE_W-1:0] ID_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

	typedef struct packed {
		logic                      cmd;
		logic [INDEX_W-1:0]        index;
		logic signed [VALUE_W-1:0] value;
	} request_t;

	typedef struct packed {
		logic                  found;
		logic [POSITION_W-1:0] position;
		logic [MOVES_W-1:0]    moves;
	} search_result_t;

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      in_valid  = 1'b0;
	logic                      in_stall;
	logic                      cmd       = CMD_LOAD;
	logic [INDEX_W-1:0]        index     = '0;
	logic signed [VALUE_W-1:0] value     = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic                      found;
	logic [POSITION_W-1:0]     position;
	logic [MOVES_W-1:0]        moves;
	logic                      cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index = REG_ENTRY_COUNT;
	logic [CFG_W-1:0]          cfg_wdata = '0;

	jump_search_move_counter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.index     (index),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.found     (found),
		.position  (position),
		.moves     (moves),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Mirror of the block: table contents and the two registers.
	logic signed [VALUE_W-1:0] id_mem [SLOTS];
	logic [CFG_W-1:0]          count_cfg = ENTRY_COUNT_RST;
	logic [CFG_W-1:0]          step_cfg  = JUMP_STEP_RST;

	// Table as it will stand once every queued request has been taken.
	logic signed [VALUE_W-1:0] plan_mem [SLOTS];

	request_t       requests_q [$];
	search_result_t search_results_q [$];

	logic        req_taken    = 1'b0;
	int unsigned idle_pct     = 15;
	int unsigned send_gap     = 0;
	int unsigned stall_gap    = 0;
	int unsigned quiet_cycles = 0;
	int unsigned err_count    = 0;
	int unsigned planned      = 0;

	function automatic search_result_t jump_search(input logic signed [VALUE_W-1:0] key);
		int unsigned n, s, pos, first, i, mv;
		bit hit, scan;
		search_result_t r;
		r = '0;
		n = (count_cfg > SLOTS) ? SLOTS : count_cfg;
		s = (step_cfg == 0) ? 1 : step_cfg;
		pos = 0;
		mv = 0;
		hit = 0;
		scan = 0;
		while (pos < n) begin
			if (id_mem[pos] == key) begin
				hit = 1;
				r.position = POSITION_W'(pos);
				break;
			end
			if (id_mem[pos] > key) begin
				scan = 1;
				break;
			end
			pos += s;
			mv += s;
		end
		if (!hit && pos >= n && pos > 0)
			scan = 1;
		if (scan) begin
			first = (pos >= s) ? pos - s : 0;
			mv += s;
			for (i = first; i < n; i++) begin
				mv++;
				if (id_mem[i] == key) begin
					hit = 1;
					r.position = POSITION_W'(i);
					break;
				end
				if (id_mem[i] > key)
					break;
			end
		end
		r.found = hit;
		r.moves = (mv > MOVES_MAX) ? MOVES_MAX : MOVES_W'(mv);
		return r;
	endfunction

	// Request driver.
	always @(negedge clk) begin
		request_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && !req_taken)) begin
			if (send_gap != 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (requests_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				r = requests_q.pop_front();
				cmd <= r.cmd;
				index <= r.index;
				value <= r.value;
				in_valid <= 1'b1;
			end else if (requests_q.size() != 0) begin
				send_gap = $urandom_range(0, 17);
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure.
	always @(negedge clk) begin
		if (stall_gap != 0) begin
			stall_gap--;
			out_stall <= 1'b1;
		end else if (arst_n && $urandom_range(0, 99) < idle_pct) begin
			stall_gap = $urandom_range(0, 17);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Monitor, predictor update and watchdog.
	always @(posedge clk) begin
		search_result_t want, got;
		if (arst_n) begin
			req_taken <= in_valid && !in_stall;
			if (out_valid && !out_stall) begin
				got = '{found: found, position: position, moves: moves};
				if (search_results_q.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("%0t: unexpected result found=%0d position=%0d moves=%0d",
							$realtime, got.found, got.position, got.moves);
				end else begin
					want = search_results_q.pop_front();
					if (got.found !== want.found || got.position !== want.position ||
						got.moves !== want.moves) begin
						err_count++;
						if (err_count <= 10)
							$display("%0t: mismatch exp found=%0d position=%0d moves=%0d, %s",
								$realtime, want.found, want.position, want.moves,
								$sformatf("got found=%0d position=%0d moves=%0d",
									got.found, got.position, got.moves));
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (cmd == CMD_LOAD)
					id_mem[index] = value;
				else
					search_results_q.push_back(jump_search(value));
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("jump_search_move_counter test failed");
					$finish;
				end
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		if (idx == REG_ENTRY_COUNT)
			count_cfg = data;
		else
			step_cfg = data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_search(input int unsigned cnt, input int unsigned stp);
		write_reg(REG_ENTRY_COUNT, CFG_W'(cnt));
		write_reg(REG_JUMP_STEP, CFG_W'(stp));
	endtask

	task automatic wait_drained();
		while (requests_q.size() != 0 || in_valid || search_results_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_load(input int unsigned slot, input logic signed [VALUE_W-1:0] id);
		request_t r;
		r.cmd = CMD_LOAD;
		r.index = INDEX_W'(slot);
		r.value = id;
		plan_mem[slot] = id;
		requests_q.push_back(r);
		planned++;
	endtask

	task automatic push_query(input logic signed [VALUE_W-1:0] key);
		request_t r;
		r.cmd = CMD_QUERY;
		r.index = INDEX_W'($urandom_range(0, SLOTS - 1));
		r.value = key;
		requests_q.push_back(r);
		planned++;
	endtask

	// Ascending IDs into slots 0..n-1; dense mode gives duplicates and near misses.
	task automatic load_ascending(input int unsigned n, input bit dense);
		longint span, v;
		int unsigned i;
		if (n != 0) begin
			if (dense) begin
				span = 4;
				v = longint'($signed($urandom));
				if (v > longint'(ID_MAX) - 4 * n)
					v = longint'(ID_MAX) - 4 * n;
			end else begin
				span = 64'h1_0000_0000 / (n + 1);
				v = longint'(ID_MIN) + $urandom_range(0, 32'(span - 1));
			end
			for (i = 0; i < n; i++) begin
				push_load(i, VALUE_W'(v));
				v += $urandom_range(0, 32'(span - 1));
			end
		end
	endtask

	function automatic logic signed [VALUE_W-1:0] pick_key(input int unsigned n);
		logic signed [VALUE_W-1:0] k;
		k = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: if (n != 0) k = plan_mem[$urandom_range(0, n - 1)];
			5, 6: if (n != 0) k = plan_mem[$urandom_range(0, n - 1)] +
				($urandom_range(0, 1) ? 1 : -1);
			7: k = $urandom_range(0, 1) ? ID_MIN : ID_MAX;
			default: k = $urandom;
		endcase
		return k;
	endfunction

	task automatic search_phase(input int unsigned cnt, input int unsigned stp,
		input int unsigned nq, input bit refill, input bit quiet);
		int unsigned n, k;
		wait_drained();
		set_search(cnt, stp);
		case ($urandom_range(0, 3))
			0: idle_pct = 0;
			1: idle_pct = 5;
			2: idle_pct = 15;
			default: idle_pct = 30;
		endcase
		if (quiet)
			idle_pct = 0;
		n = (cnt > SLOTS) ? SLOTS : cnt;
		if (refill)
			load_ascending(n, $urandom_range(0, 3) == 0);
		for (k = 0; k < nq; k++) begin
			if ($urandom_range(0, 9) == 0)
				push_load($urandom_range(0, SLOTS - 1), $urandom);
			else
				push_query(pick_key(n));
		end
	endtask

	task automatic random_phase(input bit quiet);
		int unsigned cnt, stp, n, r;
		cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(41, 511) : $urandom_range(1, 40);
		n = (cnt > SLOTS) ? SLOTS : cnt;
		r = $urandom_range(0, 9);
		if (r < 7) begin
			stp = 1;
			while ((stp + 1) * (stp + 1) <= n)
				stp++;
		end else if (r < 9) begin
			stp = $urandom_range(1, 8);
		end else begin
			stp = $urandom_range(0, 511);
		end
		search_phase(cnt, stp, (n > 64) ? 15 : 40, $urandom_range(0, 9) < 7, quiet);
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Empty table straight out of reset.
		push_query(0);
		push_query(ID_MAX);

		// Small hand-built table.
		wait_drained();
		set_search(8, 3);
		push_load(0, ID_MIN + 1);
		push_load(1, -1000);
		push_load(2, -5);
		push_load(3, 0);
		push_load(4, 7);
		push_load(5, 7);
		push_load(6, 100);
		push_load(7, ID_MAX);
		push_load(SLOTS - 1, ID_MIN);
		push_query(ID_MIN);
		push_query(ID_MIN + 1);
		push_query(ID_MAX);
		push_query(-6);
		push_query(7);
		push_query(50);
		push_query(100);
		push_query(0);

		// Whole table loaded here; every slot stays written from now on.
		search_phase(256, 16, 30, 1, 0);
		search_phase(1, 1, 12, 1, 0);
		search_phase(2, 1, 12, 1, 0);
		search_phase(2, 2, 12, 0, 0);
		search_phase(5, 2, 20, 1, 0);
		search_phase(37, 6, 30, 1, 0);
		search_phase(100, 10, 25, 1, 0);
		search_phase(64, 8, 25, 0, 0);
		search_phase(300, 17, 20, 0, 0);
		search_phase(256, 0, 8, 0, 0);
		search_phase(511, 511, 8, 0, 0);
		search_phase(256, 256, 8, 0, 0);
		search_phase(0, 5, 6, 0, 0);
		search_phase(256, 255, 8, 0, 0);
		while (planned < PLANNED_TARGET)
			random_phase(0);
		random_phase(1);
		random_phase(1);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("jump_search_move_counter test passed");
		else
			$display("jump_search_move_counter test failed");
		$finish;
	end

endmodule

// File: files.f
rtl/core/jsmc_pkg.sv
rtl/core/jsmc_ram.sv
rtl/core/jsmc_dp.sv
rtl/core/jsmc_ctrl.sv
rtl/core/jump_search_move_counter.sv
rtl/core/jsmc_checker.sv
tb/jump_search_move_counter_tb.sv
